// ----- sv/lfga_pkg.sv -----
// Shared types, constants and arctangent table for the leg foot ground angle block.
`default_nettype none
package lfga_pkg;

    // CORDIC depth, clamped to the table length
    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_ENTRIES  = 24;
    localparam int NSTG = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;

    // widths
    localparam int ANG_W = 40;   // Q28 absolute angles
    localparam int XY_W  = 34;   // CORDIC x/y
    localparam int Z_W   = 32;   // CORDIC residual angle
    localparam int P_W   = 51;   // sine times length
    localparam int H_W   = 52;   // joint height, Q30
    localparam int HQ_W  = 31;   // |h| in Q14
    localparam int SQ_D_W = 61;  // radicand
    localparam int SQ_R_W = 62;  // root accumulator
    localparam int SQ_STAGES = 31;
    localparam int F_W   = 42;   // final angle arithmetic

    localparam logic signed [ANG_W-1:0] HALF_PI_Q28 = 40'sd421657428;
    localparam logic [ANG_W-1:0] TWO_PI_U = 40'd1686629713;
    localparam logic signed [Z_W-1:0] PI_Z      = 32'sd843314857;
    localparam logic signed [Z_W-1:0] HALF_PI_Z = 32'sd421657428;
    localparam logic signed [Z_W-1:0] TWO_PI_Z  = 32'sd1686629713;
    localparam logic signed [F_W-1:0] THREE_HALF_PI_F = 42'sd1264972285;
    localparam logic signed [XY_W-1:0] GAIN_Q30 = 34'sd652032874;
    localparam logic signed [F_W-1:0] ROUND_HALF = 42'sd32768;

    typedef struct packed {
        logic [15:0]             hip;
        logic [15:0]             knee;
        logic signed [ANG_W-1:0] a1;
        logic signed [ANG_W-1:0] a2;
        logic signed [15:0]      elev;
        logic [15:0]             top_len;
        logic [15:0]             mid_len;
        logic [15:0]             bot_len;
        logic [HQ_W-1:0]         hq;
        logic                    unreach;
    } side_t;

    typedef struct packed {
        logic [15:0] hip;
        logic [15:0] knee;
        logic [15:0] ankle;
        logic        unreach;
    } result_t;

    function automatic logic signed [Z_W-1:0] atan_q28(input int unsigned i);
        logic signed [Z_W-1:0] v;
        case (i)
            0:  v = 32'sd210828714;
            1:  v = 32'sd124459457;
            2:  v = 32'sd65760959;
            3:  v = 32'sd33381290;
            4:  v = 32'sd16755422;
            5:  v = 32'sd8385879;
            6:  v = 32'sd4193963;
            7:  v = 32'sd2097109;
            8:  v = 32'sd1048571;
            9:  v = 32'sd524287;
            10: v = 32'sd262144;
            11: v = 32'sd131072;
            12: v = 32'sd65536;
            13: v = 32'sd32768;
            14: v = 32'sd16384;
            15: v = 32'sd8192;
            16: v = 32'sd4096;
            17: v = 32'sd2048;
            18: v = 32'sd1024;
            19: v = 32'sd512;
            20: v = 32'sd256;
            21: v = 32'sd128;
            22: v = 32'sd64;
            23: v = 32'sd32;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ----- sv/lfga_if.sv -----
// Valid/ready channel interfaces for leg inputs and ankle results.
`default_nettype none
interface lfga_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] hip_elevation;
    logic [15:0]        top_length;
    logic [15:0]        mid_length;
    logic [15:0]        bottom_length;
    logic signed [15:0] hip_angle;
    logic signed [15:0] knee_angle;
    logic signed [15:0] ankle_angle;
    modport source (output valid, hip_elevation, top_length, mid_length, bottom_length,
                    hip_angle, knee_angle, ankle_angle, input ready);
    modport sink (input valid, hip_elevation, top_length, mid_length, bottom_length,
                  hip_angle, knee_angle, ankle_angle, output ready);
endinterface

interface lfga_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] hip_angle_out;
    logic signed [15:0] knee_angle_out;
    logic signed [15:0] ankle_angle_out;
    logic               unreachable;
    modport source (output valid, hip_angle_out, knee_angle_out, ankle_angle_out,
                    unreachable, input ready);
    modport sink (input valid, hip_angle_out, knee_angle_out, ankle_angle_out,
                  unreachable, output ready);
endinterface
`default_nettype wire

// ----- sv/lfga_sin.sv -----
// Two-lane pipelined sine: angle reduction, folding and rotation CORDIC.
`default_nettype none
module lfga_sin
    import lfga_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    en,
    input  wire logic                    in_vld,
    input  wire logic signed [ANG_W-1:0] in_a0,
    input  wire logic signed [ANG_W-1:0] in_a1,
    input  wire side_t                   in_side,
    output logic                         out_vld,
    output logic signed [XY_W-1:0]       out_s0,
    output logic signed [XY_W-1:0]       out_s1,
    output side_t                        out_side
);

    // truncating remainder by 2pi; |a| stays below three turns
    function automatic logic signed [Z_W-1:0] trunc_rem(input logic signed [ANG_W-1:0] a);
        logic [ANG_W-1:0] mag;
        logic [ANG_W-1:0] rem;
        mag = a[ANG_W-1] ? ANG_W'(-a) : ANG_W'(a);
        if (mag >= 3 * TWO_PI_U)
            rem = mag - 3 * TWO_PI_U;
        else if (mag >= 2 * TWO_PI_U)
            rem = mag - 2 * TWO_PI_U;
        else if (mag >= TWO_PI_U)
            rem = mag - TWO_PI_U;
        else
            rem = mag;
        return a[ANG_W-1] ? -$signed(Z_W'(rem)) : $signed(Z_W'(rem));
    endfunction

    function automatic logic signed [Z_W-1:0] fold(input logic signed [Z_W-1:0] r);
        logic signed [Z_W-1:0] t;
        t = r;
        if (t > PI_Z)
            t = t - TWO_PI_Z;
        if (t < -PI_Z)
            t = t + TWO_PI_Z;
        if (t > HALF_PI_Z)
            t = PI_Z - t;
        else if (t < -HALF_PI_Z)
            t = -PI_Z - t;
        return t;
    endfunction

    logic signed [Z_W-1:0]  rd_reg [2];
    logic                   rd_vld_reg;
    side_t                  rd_side_reg;

    logic signed [XY_W-1:0] x_reg [2][NSTG+1];
    logic signed [XY_W-1:0] y_reg [2][NSTG+1];
    logic signed [Z_W-1:0]  z_reg [2][NSTG+1];
    logic                   vld_reg [NSTG+1];
    side_t                  side_reg [NSTG+1];

    // reduce
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_vld_reg <= 1'b0;
        else if (en)
            rd_vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rd_reg[0]   <= trunc_rem(in_a0);
            rd_reg[1]   <= trunc_rem(in_a1);
            rd_side_reg <= in_side;
        end
    end

    // fold into the CORDIC range and seed the rotation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (en)
            vld_reg[0] <= rd_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= rd_side_reg;
            z_reg[0][0] <= fold(rd_reg[0]);
            z_reg[1][0] <= fold(rd_reg[1]);
            x_reg[0][0] <= GAIN_Q30;
            x_reg[1][0] <= GAIN_Q30;
            y_reg[0][0] <= '0;
            y_reg[1][0] <= '0;
        end
    end

    for (genvar i = 0; i < NSTG; i++)
    begin : g_stage
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i+1] <= 1'b0;
            else if (en)
                vld_reg[i+1] <= vld_reg[i];
        end

        for (genvar l = 0; l < 2; l++)
        begin : g_lane
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (z_reg[l][i] >= 0)
                    begin
                        x_reg[l][i+1] <= x_reg[l][i] - (y_reg[l][i] >>> i);
                        y_reg[l][i+1] <= y_reg[l][i] + (x_reg[l][i] >>> i);
                        z_reg[l][i+1] <= z_reg[l][i] - atan_q28(i);
                    end
                    else
                    begin
                        x_reg[l][i+1] <= x_reg[l][i] + (y_reg[l][i] >>> i);
                        y_reg[l][i+1] <= y_reg[l][i] - (x_reg[l][i] >>> i);
                        z_reg[l][i+1] <= z_reg[l][i] + atan_q28(i);
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
                side_reg[i+1] <= side_reg[i];
        end
    end

    assign out_vld  = vld_reg[NSTG];
    assign out_s0   = y_reg[0][NSTG];
    assign out_s1   = y_reg[1][NSTG];
    assign out_side = side_reg[NSTG];

endmodule
`default_nettype wire

// ----- sv/lfga_sqrt.sv -----
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module lfga_sqrt
    import lfga_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_vld,
    input  wire logic [SQ_D_W-1:0] in_d,
    input  wire side_t             in_side,
    output logic                   out_vld,
    output logic [HQ_W-1:0]        out_root,
    output side_t                  out_side
);

    logic [SQ_D_W-1:0] d_reg   [SQ_STAGES+1];
    logic [SQ_R_W-1:0] res_reg [SQ_STAGES+1];
    logic              vld_reg [SQ_STAGES+1];
    side_t             side_reg [SQ_STAGES+1];

    assign d_reg[0]    = in_d;
    assign res_reg[0]  = '0;
    assign vld_reg[0]  = in_vld;
    assign side_reg[0] = in_side;

    for (genvar k = 0; k < SQ_STAGES; k++)
    begin : g_stage
        localparam logic [SQ_R_W-1:0] BIT = SQ_R_W'(1) << (2 * (SQ_STAGES - 1 - k));
        logic [SQ_R_W-1:0] trial;

        assign trial = res_reg[k] + BIT;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k+1] <= 1'b0;
            else if (en)
                vld_reg[k+1] <= vld_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[k+1] <= side_reg[k];
                if (SQ_R_W'(d_reg[k]) >= trial)
                begin
                    d_reg[k+1]   <= SQ_D_W'(SQ_R_W'(d_reg[k]) - trial);
                    res_reg[k+1] <= (res_reg[k] >> 1) + BIT;
                end
                else
                begin
                    d_reg[k+1]   <= d_reg[k];
                    res_reg[k+1] <= res_reg[k] >> 1;
                end
            end
        end
    end

    assign out_vld  = vld_reg[SQ_STAGES];
    assign out_root = res_reg[SQ_STAGES][HQ_W-1:0];
    assign out_side = side_reg[SQ_STAGES];

endmodule
`default_nettype wire

// ----- sv/lfga_atan.sv -----
// Pipelined vectoring CORDIC giving the Q28 angle of a non-negative vector.
`default_nettype none
module lfga_atan
    import lfga_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            in_vld,
    input  wire logic [HQ_W-1:0] in_x,
    input  wire logic [HQ_W-1:0] in_y,
    input  wire side_t           in_side,
    output logic                 out_vld,
    output logic signed [Z_W-1:0] out_theta,
    output side_t                out_side
);

    logic signed [XY_W-1:0] x_reg [NSTG+1];
    logic signed [XY_W-1:0] y_reg [NSTG+1];
    logic signed [Z_W-1:0]  z_reg [NSTG+1];
    logic                   vld_reg [NSTG+1];
    side_t                  side_reg [NSTG+1];

    assign x_reg[0]    = $signed(XY_W'(in_x));
    assign y_reg[0]    = $signed(XY_W'(in_y));
    assign z_reg[0]    = '0;
    assign vld_reg[0]  = in_vld;
    assign side_reg[0] = in_side;

    for (genvar i = 0; i < NSTG; i++)
    begin : g_stage
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i+1] <= 1'b0;
            else if (en)
                vld_reg[i+1] <= vld_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[i+1] <= side_reg[i];
                if (y_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_q28(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_q28(i);
                end
            end
        end
    end

    assign out_vld   = vld_reg[NSTG];
    assign out_theta = z_reg[NSTG];
    assign out_side  = side_reg[NSTG];

endmodule
`default_nettype wire

// ----- sv/leg_foot_ground_angle.sv -----
// Top level: three-segment leg, bottom joint angle that puts the foot on the ground.
//
//  channel   direction  handshake      payload
//  leg_in    sink       valid/ready    elevation, three lengths, three joint angles
//  leg_out   source     valid/ready    hip and knee angles, new ankle angle, unreachable
//
// One transaction enters per cycle and one result leaves per cycle, sustained while leg_out
// stays ready. From acceptance to leg_out.valid the stages are: entry, reduce and fold,
// the two sine CORDICs side by side, five multiply/height stages, 31 root stages, the
// arctangent CORDIC, one selection stage and the output register.
// rst_n clears every valid bit at once; payload registers carry no reset.
// The whole pipeline advances together; a skid register behind the output register
// absorbs one result while leg_out stalls, and leg_in.ready drops only once it is full.
`default_nettype none
module leg_foot_ground_angle
    import lfga_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    lfga_in_if.sink    leg_in,
    lfga_out_if.source leg_out
);

    logic en;

    // entry: absolute angles a0, a1, a2 in Q28
    logic                    e_vld_reg;
    logic signed [ANG_W-1:0] e_a0_reg;
    side_t                   e_side_reg;
    side_t                   e_side_next;
    logic signed [ANG_W-1:0] a0_next;
    logic signed [ANG_W-1:0] a1_next;
    logic signed [ANG_W-1:0] a2_next;

    // sine outputs
    logic                   s_vld;
    logic signed [XY_W-1:0] s0;
    logic signed [XY_W-1:0] s1;
    side_t                  s_side;

    // height and radicand stages
    logic                   m1_vld_reg, m2_vld_reg, m3_vld_reg, m4_vld_reg, m5_vld_reg;
    side_t                  m1_side_reg, m2_side_reg, m3_side_reg, m4_side_reg, m5_side_reg;
    side_t                  m3_side_next;
    logic signed [P_W-1:0]  p0_reg, p1_reg;
    logic signed [H_W-1:0]  h_reg;
    logic [H_W-1:0]         habs;
    logic [31:0]            bot2_reg;
    logic [2*HQ_W-1:0]      hq2_reg;
    logic [SQ_D_W-1:0]      d_reg;

    // root and arctangent outputs
    logic                  q_vld;
    logic [HQ_W-1:0]       root;
    side_t                 q_side;
    logic                  t_vld;
    logic signed [Z_W-1:0] theta;
    side_t                 t_side;

    // candidate selection
    logic                  f1_vld_reg;
    side_t                 f1_side_reg;
    logic [F_W-1:0]        dhi_reg, dlo_reg;
    logic signed [F_W-1:0] ahi_reg, alo_reg;
    logic signed [F_W-1:0] th, hi, lo, dhi_s, dlo_s;
    logic                  f2_vld;
    result_t               f2_res;
    logic signed [F_W-17:0] v;

    // output register and skid
    logic    out_vld_reg, skid_vld_reg;
    result_t out_res_reg, skid_res_reg;

    // ---------------- entry ----------------
    assign en           = !skid_vld_reg;
    assign leg_in.ready = en;

    always_comb
    begin
        a0_next = HALF_PI_Q28 - (ANG_W'(leg_in.hip_angle) <<< 16);
        a1_next = a0_next - (ANG_W'(leg_in.knee_angle) <<< 16);
        a2_next = a1_next - (ANG_W'(leg_in.ankle_angle) <<< 16);

        e_side_next.hip     = leg_in.hip_angle;
        e_side_next.knee    = leg_in.knee_angle;
        e_side_next.a1      = a1_next;
        e_side_next.a2      = a2_next;
        e_side_next.elev    = leg_in.hip_elevation;
        e_side_next.top_len = leg_in.top_length;
        e_side_next.mid_len = leg_in.mid_length;
        e_side_next.bot_len = leg_in.bottom_length;
        e_side_next.hq      = '0;
        e_side_next.unreach = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e_vld_reg <= 1'b0;
        else if (en)
            e_vld_reg <= leg_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_a0_reg   <= a0_next;
            e_side_reg <= e_side_next;
        end
    end

    // ---------------- sines of a0 and a1 ----------------
    lfga_sin u_sin (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (e_vld_reg),
        .in_a0    (e_a0_reg),
        .in_a1    (e_side_reg.a1),
        .in_side  (e_side_reg),
        .out_vld  (s_vld),
        .out_s0   (s0),
        .out_s1   (s1),
        .out_side (s_side)
    );

    // ---------------- joint height and radicand ----------------
    assign habs = h_reg[H_W-1] ? H_W'(-h_reg) : H_W'(h_reg);

    // flag out of reach and take |h| down to Q14
    always_comb
    begin
        m3_side_next         = m2_side_reg;
        m3_side_next.unreach = habs > (H_W'(m2_side_reg.bot_len) << 30);
        m3_side_next.hq      = habs[HQ_W+15:16];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_vld_reg <= 1'b0;
            m2_vld_reg <= 1'b0;
            m3_vld_reg <= 1'b0;
            m4_vld_reg <= 1'b0;
            m5_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            m1_vld_reg <= s_vld;
            m2_vld_reg <= m1_vld_reg;
            m3_vld_reg <= m2_vld_reg;
            m4_vld_reg <= m3_vld_reg;
            m5_vld_reg <= m4_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // weight each sine by its segment length
            p0_reg      <= P_W'(s0) * P_W'($signed({1'b0, s_side.top_len}));
            p1_reg      <= P_W'(s1) * P_W'($signed({1'b0, s_side.mid_len}));
            m1_side_reg <= s_side;

            // sum with the hip elevation, Q30
            h_reg       <= (H_W'(m1_side_reg.elev) <<< 30) + H_W'(p0_reg) + H_W'(p1_reg);
            m2_side_reg <= m1_side_reg;

            m3_side_reg <= m3_side_next;

            // squares of the bottom length and |h|, the hypotenuse and one leg of the triangle
            bot2_reg    <= 32'(m3_side_reg.bot_len) * 32'(m3_side_reg.bot_len);
            hq2_reg     <= (2*HQ_W)'(m3_side_reg.hq) * (2*HQ_W)'(m3_side_reg.hq);
            m4_side_reg <= m3_side_reg;

            // radicand; meaningful only when the ground is in reach
            d_reg       <= SQ_D_W'({bot2_reg, 28'b0} - hq2_reg);
            m5_side_reg <= m4_side_reg;
        end
    end

    // ---------------- square root and arctangent ----------------
    lfga_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (m5_vld_reg),
        .in_d     (d_reg),
        .in_side  (m5_side_reg),
        .out_vld  (q_vld),
        .out_root (root),
        .out_side (q_side)
    );

    lfga_atan u_atan (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_vld    (q_vld),
        .in_x      (q_side.hq),
        .in_y      (root),
        .in_side   (q_side),
        .out_vld   (t_vld),
        .out_theta (theta),
        .out_side  (t_side)
    );

    // ---------------- candidate selection ----------------
    always_comb
    begin
        // zero bottom length: the foot is at the joint, theta counts as zero
        th    = (t_side.bot_len == '0) ? '0 : F_W'(theta);
        hi    = THREE_HALF_PI_F + th;
        lo    = THREE_HALF_PI_F - th;
        dhi_s = F_W'(t_side.a2) - hi;
        dlo_s = F_W'(t_side.a2) - lo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f1_vld_reg <= 1'b0;
        else if (en)
            f1_vld_reg <= t_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dhi_reg     <= dhi_s[F_W-1] ? F_W'(-dhi_s) : F_W'(dhi_s);
            dlo_reg     <= dlo_s[F_W-1] ? F_W'(-dlo_s) : F_W'(dlo_s);
            ahi_reg     <= F_W'(t_side.a1) - hi + ROUND_HALF;
            alo_reg     <= F_W'(t_side.a1) - lo + ROUND_HALF;
            f1_side_reg <= t_side;
        end
    end

    // round to Q4.12, saturate; a tie takes the lower candidate
    always_comb
    begin
        v = (dhi_reg < dlo_reg) ? ahi_reg[F_W-1:16] : alo_reg[F_W-1:16];
        f2_vld         = f1_vld_reg;
        f2_res.hip     = f1_side_reg.hip;
        f2_res.knee    = f1_side_reg.knee;
        f2_res.unreach = f1_side_reg.unreach;
        if (f1_side_reg.unreach)
            f2_res.ankle = '0;
        else if (v > 26'sd32767)
            f2_res.ankle = 16'h7fff;
        else if (v < -26'sd32768)
            f2_res.ankle = 16'h8000;
        else
            f2_res.ankle = v[15:0];
    end

    // ---------------- output register and skid ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (out_vld_reg && !leg_out.ready)
        begin
            // hold the result; park a newcomer in the skid
            if (en && f2_vld)
                skid_vld_reg <= 1'b1;
        end
        else if (skid_vld_reg)
        begin
            out_vld_reg  <= 1'b1;
            skid_vld_reg <= 1'b0;
        end
        else
            out_vld_reg <= f2_vld;
    end

    always_ff @(posedge clk)
    begin
        if (out_vld_reg && !leg_out.ready)
        begin
            if (en)
                skid_res_reg <= f2_res;
        end
        else if (skid_vld_reg)
            out_res_reg <= skid_res_reg;
        else
            out_res_reg <= f2_res;
    end

    assign leg_out.valid           = out_vld_reg;
    assign leg_out.hip_angle_out   = out_res_reg.hip;
    assign leg_out.knee_angle_out  = out_res_reg.knee;
    assign leg_out.ankle_angle_out = out_res_reg.ankle;
    assign leg_out.unreachable     = out_res_reg.unreach;

endmodule
`default_nettype wire

// ----- sv/lfga_checker.sv -----
// Port-level checks for the leg foot ground angle block, bound to the top level.
`default_nettype none
module lfga_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [15:0] ankle,
    input wire logic        unreachable
);

    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(ankle) && $stable(unreachable))
        else $error("result changed while stalled");

    // input back-pressure only comes from a waiting result
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input blocked with no result waiting");

    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(out_valid && !out_ready))
        else $error("input blocked without an output stall");

    // out of reach gives a zero ankle
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && unreachable |-> ankle == 16'h0000)
        else $error("unreachable result with nonzero ankle");

endmodule

bind leg_foot_ground_angle lfga_checker u_lfga_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (leg_in.ready),
    .out_valid   (leg_out.valid),
    .out_ready   (leg_out.ready),
    .ankle       (leg_out.ankle_angle_out),
    .unreachable (leg_out.unreachable)
);
`default_nettype wire

// ----- bench/lfga_bench_pkg.sv -----
// Leg item type shared by the testbench top and the checker.
package lfga_bench_pkg;

    typedef struct {
        logic signed [15:0] elev;
        logic [15:0]        top_len;
        logic [15:0]        mid_len;
        logic [15:0]        bot_len;
        logic signed [15:0] hip;
        logic signed [15:0] knee;
        logic signed [15:0] ankle;
    } leg_item_t;

endpackage

// ----- bench/lfga_ankle_checker.sv -----
// Checker: predicts the ground-contact ankle angle and compares every result.
module lfga_ankle_checker
    import lfga_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    lfga_in_if         leg_in,
    lfga_out_if        leg_out,
    input  logic       out_ready,
    output int         fail_count,
    output int         pending
);

    localparam longint PI_Q     = 64'sd843314857;
    localparam longint HALF_PI  = 64'sd421657428;
    localparam longint TWO_PI   = 64'sd1686629713;
    localparam longint TH_PI    = 64'sd1264972285;
    localparam longint GAIN     = 64'sd652032874;

    result_t ankle_q[$];

    function automatic longint tbl(int i);
        return longint'(atan_q28(i));
    endfunction

    function automatic longint sine_q30(longint a);
        longint r, x, y, nx;
        r = a % TWO_PI;
        x = GAIN;
        y = 0;
        if (r > PI_Q) r -= TWO_PI;
        if (r < -PI_Q) r += TWO_PI;
        if (r > HALF_PI) r = PI_Q - r;
        else if (r < -HALF_PI) r = -PI_Q - r;
        for (int i = 0; i < NSTG; i++)
        begin
            if (r >= 0)
            begin
                nx = x - (y >>> i); y = y + (x >>> i); r -= tbl(i);
            end
            else
            begin
                nx = x + (y >>> i); y = y - (x >>> i); r += tbl(i);
            end
            x = nx;
        end
        return y;
    endfunction

    function automatic longint vector_angle(longint x, longint y);
        longint z, nx;
        z = 0;
        for (int i = 0; i < NSTG; i++)
        begin
            if (y >= 0)
            begin
                nx = x + (y >>> i); y = y - (x >>> i); z += tbl(i);
            end
            else
            begin
                nx = x - (y >>> i); y = y + (x >>> i); z -= tbl(i);
            end
            x = nx;
        end
        return z;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned d);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > d) b >>= 2;
        while (b != 0)
        begin
            if (d >= res + b)
            begin
                d -= res + b; res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic result_t ground_ankle(lfga_bench_pkg::leg_item_t it);
        result_t r;
        longint a0, a1, a2, h, habs, bot, theta, hq, lq, hi, lo, dhi, dlo, pick, v;
        bot = longint'(it.bot_len);
        a0 = HALF_PI - longint'(it.hip) * 65536;
        a1 = a0 - longint'(it.knee) * 65536;
        a2 = a1 - longint'(it.ankle) * 65536;
        h = longint'(it.elev) * (64'sd1 <<< 30) + sine_q30(a0) * longint'(it.top_len)
            + sine_q30(a1) * longint'(it.mid_len);
        habs = (h < 0) ? -h : h;
        r.hip = it.hip;
        r.knee = it.knee;
        r.ankle = '0;
        r.unreach = 1'b0;
        if (habs > bot * (64'sd1 <<< 30))
            r.unreach = 1'b1;
        else
        begin
            theta = 0;
            if (bot != 0)
            begin
                hq = habs >>> 16;
                lq = bot <<< 14;
                theta = vector_angle(hq, longint'(root_floor(lq * lq - hq * hq)));
            end
            hi = TH_PI + theta;
            lo = TH_PI - theta;
            dhi = a2 - hi; if (dhi < 0) dhi = -dhi;
            dlo = a2 - lo; if (dlo < 0) dlo = -dlo;
            pick = (dhi < dlo) ? hi : lo;
            v = (a1 - pick + 32768) >>> 16;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            r.ankle = v[15:0];
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        lfga_bench_pkg::leg_item_t it;
        result_t exp_r;
        if (rst_n && leg_in.valid && leg_in.ready)
        begin
            it.elev = leg_in.hip_elevation;  it.top_len = leg_in.top_length;
            it.mid_len = leg_in.mid_length;  it.bot_len = leg_in.bottom_length;
            it.hip = leg_in.hip_angle;       it.knee = leg_in.knee_angle;
            it.ankle = leg_in.ankle_angle;
            ankle_q = {ankle_q, ground_ankle(it)};
        end
        if (rst_n && leg_out.valid && out_ready)
        begin
            if (ankle_q.size() == 0)
            begin
                $error("result with nothing expected");
                fail_count++;
            end
            else
            begin
                exp_r = ankle_q.pop_front();
                if (leg_out.hip_angle_out !== exp_r.hip)
                begin
                    $error("hip_angle_out expected %0h got %0h", exp_r.hip,
                           leg_out.hip_angle_out);
                    fail_count++;
                end
                if (leg_out.knee_angle_out !== exp_r.knee)
                begin
                    $error("knee_angle_out expected %0h got %0h", exp_r.knee,
                           leg_out.knee_angle_out);
                    fail_count++;
                end
                if (leg_out.unreachable !== exp_r.unreach)
                begin
                    $error("unreachable expected %0b got %0b", exp_r.unreach,
                           leg_out.unreachable);
                    fail_count++;
                end
                // out of reach predicts a zero ankle
                if (leg_out.ankle_angle_out !== exp_r.ankle)
                begin
                    $error("ankle_angle_out expected %0h got %0h", exp_r.ankle,
                           leg_out.ankle_angle_out);
                    fail_count++;
                end
            end
        end
        pending = ankle_q.size();
    end

    initial
    begin
        fail_count = 0;
        pending = 0;
    end

endmodule

// ----- bench/tb_leg_foot_ground_angle.sv -----
// Testbench top: stimulus, output stalls, drain and verdict for the leg block.
module tb_leg_foot_ground_angle;
    import lfga_pkg::*;
    import lfga_bench_pkg::*;

    localparam int DRAIN_CYCLES = 2 * NSTG + 60;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count;
    int   pending;

    lfga_in_if  leg_in ();
    lfga_out_if leg_out ();

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    leg_foot_ground_angle dut (.clk(clk), .rst_n(rst_n), .leg_in(leg_in), .leg_out(leg_out));

    lfga_ankle_checker chk (
        .clk(clk), .rst_n(rst_n), .leg_in(leg_in), .leg_out(leg_out),
        .out_ready(leg_out.ready), .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        leg_in.valid = 1'b0;
        leg_in.hip_elevation = '0; leg_in.top_length = '0; leg_in.mid_length = '0;
        leg_in.bottom_length = 16'd1; leg_in.hip_angle = '0; leg_in.knee_angle = '0;
        leg_in.ankle_angle = '0;
        leg_out.ready = 1'b0;
    end

    // Output stalls: draw a wait per result, with stall-free stretches in between.
    initial
    begin
        int w;
        @(posedge clk iff rst_n);
        forever
        begin
            w = ($urandom_range(0, 7) < 3) ? 0 : $urandom_range(0, 3);
            if (w > 0)
            begin
                leg_out.ready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            leg_out.ready <= 1'b1;
            @(posedge clk iff leg_out.valid);
        end
    end

    // Present one transaction, hold until accepted, then drop valid unless the
    // next one follows at once.
    task automatic send_leg(leg_item_t it, int gap);
        if (gap > 0)
        begin
            leg_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        leg_in.valid <= 1'b1;
        leg_in.hip_elevation <= it.elev;  leg_in.top_length <= it.top_len;
        leg_in.mid_length <= it.mid_len;  leg_in.bottom_length <= it.bot_len;
        leg_in.hip_angle <= it.hip;       leg_in.knee_angle <= it.knee;
        leg_in.ankle_angle <= it.ankle;
        @(posedge clk iff leg_in.ready);
    endtask

    function automatic leg_item_t leg_make(int e, int t, int m, int b, int h, int k, int a);
        leg_item_t it;
        it.elev = e; it.top_len = t; it.mid_len = m; it.bot_len = b;
        it.hip = h; it.knee = k; it.ankle = a;
        return it;
    endfunction

    // Mostly plausible legs, so the reachable branch is exercised, with raw noise mixed in.
    function automatic leg_item_t leg_random();
        leg_item_t it;
        int mode;
        mode = $urandom_range(0, 9);
        it.hip = $urandom; it.knee = $urandom; it.ankle = $urandom;
        if (mode < 2)
        begin
            it.elev = $urandom; it.top_len = $urandom; it.mid_len = $urandom;
            it.bot_len = $urandom_range(1, 65535);
        end
        else
        begin
            it.elev = $signed(16'($urandom_range(0, 4096))) - 16'sd1024;
            it.top_len = $urandom_range(0, 2048);
            it.mid_len = $urandom_range(0, 2048);
            it.bot_len = (mode == 9) ? 16'hFFFF : $urandom_range(1, 6000);
            if (mode < 6)
            begin
                it.hip = $signed(16'($urandom_range(0, 12868))) - 16'sd6434;
                it.knee = $signed(16'($urandom_range(0, 12868))) - 16'sd6434;
                it.ankle = $signed(16'($urandom_range(0, 12868))) - 16'sd6434;
            end
        end
        return it;
    endfunction

    initial
    begin
        leg_item_t dir_q[$];
        int waited;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, on-ground foot, zero-length reach, saturation
        dir_q = {
            leg_make(0, 0, 0, 1, 0, 0, 0),
            leg_make(256, 0, 0, 256, 0, 0, 0),
            leg_make(256, 0, 0, 512, 0, 0, 0),
            leg_make(-256, 0, 0, 512, 0, 0, 0),
            leg_make(512, 256, 256, 256, 0, 0, 0),
            leg_make(1024, 512, 512, 2048, 6434, -3217, 1608),
            leg_make(32767, 65535, 65535, 65535, 32767, 32767, 32767),
            leg_make(-32768, 65535, 65535, 65535, -32768, -32768, -32768),
            leg_make(0, 65535, 0, 65535, 32767, 0, 0),
            leg_make(0, 0, 65535, 65535, 0, -32768, 32767),
            leg_make(0, 0, 0, 65535, 32767, 32767, -32768),
            leg_make(0, 0, 0, 65535, -32768, -32768, 32767),
            leg_make(100, 0, 0, 100, 0, 0, 0),
            leg_make(-32768, 0, 0, 65535, 0, 0, 0),
            leg_make(1, 0, 0, 1, 12868, 0, 0),
            leg_make(0, 300, 300, 600, 6434, 6434, 6434),
            leg_make(-1, 1, 1, 1, -1, -1, -1)
        };
        foreach (dir_q[i])
            send_leg(dir_q[i], $urandom_range(0, 3));

        // hold off until the pipeline has drained once
        leg_in.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);

        for (int n = 0; n < 1600; n++)
            send_leg(leg_random(), ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : 0);
        leg_in.valid <= 1'b0;

        waited = 0;
        while (pending != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #200000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- leg_foot_ground_angle.f -----
sv/lfga_pkg.sv
sv/lfga_if.sv
sv/lfga_sin.sv
sv/lfga_sqrt.sv
sv/lfga_atan.sv
sv/leg_foot_ground_angle.sv
sv/lfga_checker.sv
bench/lfga_bench_pkg.sv
bench/lfga_ankle_checker.sv
bench/tb_leg_foot_ground_angle.sv
